// ----- sv/gdd_pkg.sv -----
// ----------------------------------------------------------------------------
// Gregorian date difference package
// Shared types, widths, constants and calendar tables for the date
// difference block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdd_pkg;

  // Field widths
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;

  // Accumulator width: a day number for any 14-bit year fits in 23 bits
  localparam int ACC_W = 23;

  // Quotient of (year - 1) / 100 fits in 8 bits for a 14-bit year
  localparam int QUO_W = 8;
  localparam int REM_W = YEAR_W;

  // Wide enough to compare a year against any allowed top year
  localparam int YCMP_W = 16;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_INCLUDE_END_DAY = 3'd0;

  // Calendar constants
  localparam logic [6:0] YEAR_REM_LAST = 7'd99;
  localparam logic [QUO_W-1:0] CENT_ONE = 8'd100;

  // Accumulation terms, one added per cycle
  localparam logic [3:0] TERM_P256  = 4'd0;
  localparam logic [3:0] TERM_P64   = 4'd1;
  localparam logic [3:0] TERM_P32   = 4'd2;
  localparam logic [3:0] TERM_P8    = 4'd3;
  localparam logic [3:0] TERM_P4    = 4'd4;
  localparam logic [3:0] TERM_P1    = 4'd5;
  localparam logic [3:0] TERM_Q16   = 4'd6;
  localparam logic [3:0] TERM_Q8    = 4'd7;
  localparam logic [3:0] TERM_QDIV4 = 4'd8;
  localparam logic [3:0] TERM_RDIV4 = 4'd9;
  localparam logic [3:0] TERM_MONTH = 4'd10;
  localparam logic [3:0] TERM_LEAP  = 4'd11;
  localparam logic [3:0] TERM_DAY   = 4'd12;

  // Months
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic               invalid_date;
  } out_t;

  typedef struct packed {
    logic             sub;
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] res;
    logic             borrow;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_ACC,
    ST_DIFF,
    ST_INC
  } st_t;

  // Days in a month, 28 for February; 0 for codes that are no month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of the month
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Divisor for one restoring division step: 100 shifted by the bit index
  function automatic logic [ACC_W-1:0] div_step(input logic [2:0] idx);
    return ACC_W'(CENT_ONE) << idx;
  endfunction

endpackage

`default_nettype wire

// ----- sv/gregorian_date_difference_days.sv -----
// One transaction at a time; the input is not ready until the result is
// handed to the output register. The work runs through the shared adder:
// per date 1 load, 8 division steps and 13 accumulation steps, then one
// subtract and one increment, which waits while an earlier result stalls.
// Reset (rst_n low, synchronous) empties the sequencer and output register
// and clears include_end_day; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Gregorian date difference
// Days between two calendar dates, computed as the difference of their
// day numbers counted from 1 January of year 1.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_difference_days #(
  parameter int unsigned MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  gdd_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output gdd_pkg::out_t                    out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gdd_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [gdd_pkg::CFG_DW-1:0]  pwdata,
  output logic      [gdd_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready
);
  import gdd_pkg::*;

  logic     include_end_day;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  gdd_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .include_end_day (include_end_day)
  );

  gdd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  gdd_ctrl #(
    .MAX_YEAR (MAX_YEAR)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .include_end_day (include_end_day),
    .alu_req         (alu_req),
    .alu_rsp         (alu_rsp)
  );

endmodule

`default_nettype wire

// ----- sv/gdd_alu.sv -----
// ----------------------------------------------------------------------------
// Shared add/subtract unit
// The shared arithmetic unit of the block: adds, or subtracts and reports
// a borrow, which doubles as the compare for the division steps.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_alu (
  input  gdd_pkg::alu_req_t req,
  output gdd_pkg::alu_rsp_t rsp
);
  import gdd_pkg::*;

  logic [ACC_W:0] sum;

  // Add or subtract with one extra bit for carry or borrow
  always_comb begin
    if (req.sub) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
  end

  assign rsp.res    = sum[ACC_W-1:0];
  assign rsp.borrow = sum[ACC_W];

endmodule

`default_nettype wire

// ----- sv/gdd_cfg.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the include-end-day control bit.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gdd_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [gdd_pkg::CFG_DW-1:0]   pwdata,
  output logic      [gdd_pkg::CFG_DW-1:0]   prdata,
  output logic                              pready,
  output logic                              include_end_day
);
  import gdd_pkg::*;

  logic inc_r;
  logic inc_nxt;
  logic hit;

  // Word select: the low two address bits are byte lanes
  assign hit = (paddr[CFG_AW-1:2] == REG_INCLUDE_END_DAY[CFG_AW-1:2]);

  // Take a write in the access phase of a transaction
  always_comb begin
    inc_nxt = inc_r;
    if (psel && penable && pwrite && pready && hit) begin
      inc_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r <= 1'b0;
    end else begin
      inc_r <= inc_nxt;
    end
  end

  assign pready          = 1'b1;
  assign prdata          = hit ? {{(CFG_DW-1){1'b0}}, inc_r} : '0;
  assign include_end_day = inc_r;

endmodule

`default_nettype wire

// ----- sv/gdd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Day difference sequencer
// Steps both dates through the shared adder: a restoring division of
// (year - 1) by 100, then an accumulation of the day number term by term,
// then the difference, the include-end-day increment and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_ctrl #(
  parameter int unsigned MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  gdd_pkg::in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gdd_pkg::out_t          out_data,
  input  wire logic              include_end_day,
  output gdd_pkg::alu_req_t      alu_req,
  input  gdd_pkg::alu_rsp_t      alu_rsp
);
  import gdd_pkg::*;

  st_t               st_r, st_nxt;
  in_t               item_r, item_nxt;
  logic              sel_r, sel_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  first_r, first_nxt;
  logic              bad_r, bad_nxt;
  logic              ov_r, ov_nxt;
  out_t              od_r, od_nxt;

  logic [DAY_W-1:0]   cur_d;
  logic [MONTH_W-1:0] cur_m;
  logic [YEAR_W-1:0]  cur_y;
  logic [YEAR_W-1:0]  cur_p;
  logic               leap;
  logic [DAY_W-1:0]   mlen;
  logic               date_ok;
  logic [ACC_W-1:0]   term;
  logic [COUNT_W-1:0] sat_count;

  // Pick the date being worked on
  always_comb begin
    if (sel_r) begin
      cur_d = item_r.end_day;
      cur_m = item_r.end_month;
      cur_y = item_r.end_year;
    end else begin
      cur_d = item_r.start_day;
      cur_m = item_r.start_month;
      cur_y = item_r.start_year;
    end
  end

  assign cur_p = cur_y - YEAR_W'(1);

  // Leap year from the division result: y = 100*q + r + 1
  always_comb begin
    if (rem_r[6:0] == YEAR_REM_LAST) begin
      leap = (quo_r[1:0] == 2'b11);
    end else begin
      leap = (cur_y[1:0] == 2'b00);
    end
  end

  // Check the date; valid once the division is done
  always_comb begin
    mlen = month_len(cur_m);
    if (cur_m == MON_FEB && leap) begin
      mlen = mlen + DAY_W'(1);
    end
    date_ok = (cur_y != '0)
           && (YCMP_W'(cur_y) <= YCMP_W'(MAX_YEAR))
           && (cur_m >= MON_JAN) && (cur_m <= MON_DEC)
           && (cur_d != '0) && (cur_d <= mlen);
  end

  // Day number terms: 365p + 24q + q/4 + r/4 + month offset + leap + d - 1
  always_comb begin
    unique case (cnt_r)
      TERM_P256:  term = ACC_W'({cur_p, 8'b0});
      TERM_P64:   term = ACC_W'({cur_p, 6'b0});
      TERM_P32:   term = ACC_W'({cur_p, 5'b0});
      TERM_P8:    term = ACC_W'({cur_p, 3'b0});
      TERM_P4:    term = ACC_W'({cur_p, 2'b0});
      TERM_P1:    term = ACC_W'(cur_p);
      TERM_Q16:   term = ACC_W'({quo_r, 4'b0});
      TERM_Q8:    term = ACC_W'({quo_r, 3'b0});
      TERM_QDIV4: term = ACC_W'(quo_r[QUO_W-1:2]);
      TERM_RDIV4: term = ACC_W'(rem_r[6:2]);
      TERM_MONTH: term = ACC_W'(days_before(cur_m));
      TERM_LEAP:  term = ACC_W'(leap && (cur_m > MON_FEB));
      TERM_DAY:   term = ACC_W'(cur_d - DAY_W'(1));
      default:    term = '0;
    endcase
  end

  // Clamp the final count to the output range
  assign sat_count = alu_rsp.res[COUNT_W] ? {COUNT_W{1'b1}} : alu_rsp.res[COUNT_W-1:0];

  // Sequencer: next state, datapath updates and adder operands
  always_comb begin
    st_nxt    = st_r;
    item_nxt  = item_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    acc_nxt   = acc_r;
    first_nxt = first_r;
    bad_nxt   = bad_r;
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    alu_req   = '{sub: 1'b0, a: acc_r, b: term};

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          sel_nxt  = 1'b0;
          bad_nxt  = 1'b0;
          st_nxt   = ST_LOAD;
        end
      end

      ST_LOAD: begin
        rem_nxt = cur_p;
        quo_nxt = '0;
        acc_nxt = '0;
        cnt_nxt = 4'd7;
        st_nxt  = ST_DIV;
      end

      // One quotient bit per cycle, most significant first
      ST_DIV: begin
        alu_req = '{sub: 1'b1, a: ACC_W'(rem_r), b: div_step(cnt_r[2:0])};
        if (!alu_rsp.borrow) begin
          rem_nxt             = alu_rsp.res[REM_W-1:0];
          quo_nxt[cnt_r[2:0]] = 1'b1;
        end
        if (cnt_r == '0) begin
          st_nxt = ST_ACC;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end

      // Add one term per cycle
      ST_ACC: begin
        acc_nxt = alu_rsp.res;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == TERM_DAY) begin
          bad_nxt = bad_r || !date_ok;
          if (!sel_r) begin
            first_nxt = alu_rsp.res;
            sel_nxt   = 1'b1;
            st_nxt    = ST_LOAD;
          end else begin
            st_nxt = ST_DIFF;
          end
        end
      end

      // End minus start, zero when the start is not earlier
      ST_DIFF: begin
        alu_req = '{sub: 1'b1, a: acc_r, b: first_r};
        acc_nxt = alu_rsp.borrow ? '0 : alu_rsp.res;
        st_nxt  = ST_INC;
      end

      // Add the end day if asked, then hand over once the output is free
      ST_INC: begin
        alu_req = '{sub: 1'b0, a: acc_r, b: ACC_W'(include_end_day)};
        if (!ov_r || out_ready) begin
          ov_nxt              = 1'b1;
          od_nxt.invalid_date = bad_r;
          od_nxt.day_count    = bad_r ? '0 : sat_count;
          st_nxt              = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    sel_r   <= sel_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    acc_r   <= acc_nxt;
    first_r <= first_nxt;
    bad_r   <= bad_nxt;
    od_r    <= od_nxt;
  end

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

`default_nettype wire

// ----- sv/gdd_chk.sv -----
// ----------------------------------------------------------------------------
// Date difference port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input gdd_pkg::out_t      out_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic          pready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // An invalid date always reports a zero count
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid_date |-> out_data.day_count == '0)
    else $error("invalid date with nonzero count");

  // One transaction in flight: input closes after acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input reopened during computation");

  // A result never appears right after acceptance
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too early");

  // Register port never stalls
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind gregorian_date_difference_days gdd_chk u_gdd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pready    (pready)
);

`default_nettype wire
